### hdl/mrq_pkg.sv
// ----------------------------------------------------------------------------
// mrq_pkg
// shared constants, types and the level mapping of the multilevel ready queue
// ----------------------------------------------------------------------------
package mrq_pkg;

	localparam int NUM_LEVELS = 8;
	localparam int MAX_TASKS  = 16;

	localparam int TASK_W = $clog2(MAX_TASKS);
	localparam int LINK_W = TASK_W + 1;
	localparam int LVL_W  = $clog2(NUM_LEVELS);
	localparam int OP_W   = 3;
	localparam int PRIO_W = 8;
	localparam int DEST_W = 8;
	localparam int LEN_W  = 16;
	localparam int STAT_W = 2;

	// link value meaning no task
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_TASKS);

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_RECV  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP        = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
	localparam logic [OP_W-1:0] OP_FIND       = 3'd5;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd2;

	// priority code mapping
	localparam logic [PRIO_W-1:0] PRIO_LO       = 8'h80;
	localparam logic [PRIO_W-1:0] PRIO_HI       = 8'h86;
	localparam logic [PRIO_W-1:0] PRIO_BIAS     = 8'h7f;
	localparam logic [PRIO_W-1:0] DEFAULT_LEVEL = 8'd4;

	typedef struct packed {
		logic [LEN_W-1:0]  max_length;
		logic [DEST_W-1:0] wanted_target;
		logic [LEN_W-1:0]  msg_length;
		logic [DEST_W-1:0] destination;
		logic [TASK_W-1:0] task_id;
		logic [LVL_W-1:0]  level;
		logic [PRIO_W-1:0] priority_req;
		logic [OP_W-1:0]   op;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [TASK_W-1:0] out_task;
		logic              found;
	} result_t;

	typedef struct packed {
		logic              next_we;
		logic [TASK_W-1:0] next_addr;
		logic [LINK_W-1:0] next_data;
		logic              prev_we;
		logic [TASK_W-1:0] prev_addr;
		logic [LINK_W-1:0] prev_data;
		logic              ent_we;
		logic [TASK_W-1:0] ent_addr;
		logic [DEST_W-1:0] ent_dest;
		logic [LEN_W-1:0]  ent_len;
	} ram_wr_t;

	typedef struct packed {
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
		logic [DEST_W-1:0] dest;
		logic [LEN_W-1:0]  len;
	} ram_rd_t;

	function automatic logic [LVL_W-1:0] code_to_level(input logic [PRIO_W-1:0] code);
		logic [PRIO_W-1:0] lv;
		if (code >= PRIO_LO && code <= PRIO_HI) begin
			lv = code - PRIO_BIAS;
		end else begin
			lv = DEFAULT_LEVEL;
		end
		if (lv >= PRIO_W'(NUM_LEVELS)) begin
			lv = PRIO_W'(NUM_LEVELS - 1);
		end
		return lv[LVL_W-1:0];
	endfunction

endpackage

### hdl/mrq_task_ram.sv
// ----------------------------------------------------------------------------
// mrq_task_ram
// per-task link and message store, one write per array, registered read
// ----------------------------------------------------------------------------
module mrq_task_ram (
	input  logic                      clk,
	input  mrq_pkg::ram_wr_t          wr,
	input  logic [mrq_pkg::TASK_W-1:0] rd_addr,
	output mrq_pkg::ram_rd_t          rd
);
	import mrq_pkg::*;

	logic [LINK_W-1:0] next_mem [MAX_TASKS];
	logic [LINK_W-1:0] prev_mem [MAX_TASKS];
	logic [DEST_W-1:0] dest_mem [MAX_TASKS];
	logic [LEN_W-1:0]  len_mem  [MAX_TASKS];

	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			next_mem[wr.next_addr] <= wr.next_data;
		end
		if (wr.prev_we) begin
			prev_mem[wr.prev_addr] <= wr.prev_data;
		end
		if (wr.ent_we) begin
			dest_mem[wr.ent_addr] <= wr.ent_dest;
			len_mem[wr.ent_addr]  <= wr.ent_len;
		end
		rd.next <= next_mem[rd_addr];
		rd.prev <= prev_mem[rd_addr];
		rd.dest <= dest_mem[rd_addr];
		rd.len  <= len_mem[rd_addr];
	end

endmodule

### hdl/mrq_ctrl.sv
// ----------------------------------------------------------------------------
// mrq_ctrl
// sequencer: level heads and tails, task levels, list walk and relinking
// ----------------------------------------------------------------------------
module mrq_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  mrq_pkg::item_t             item,
	input  logic [mrq_pkg::PRIO_W-1:0] recv_priority,
	input  logic                       res_ready,
	output logic                       res_valid,
	output mrq_pkg::result_t           res,
	output mrq_pkg::ram_wr_t           ram_wr,
	output logic [mrq_pkg::TASK_W-1:0] rd_addr,
	input  mrq_pkg::ram_rd_t           ram_rd
);
	import mrq_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DECODE = 9'b000000010,
		S_UL_RD  = 9'b000000100,
		S_UL_WR  = 9'b000001000,
		S_INS1   = 9'b000010000,
		S_INS2   = 9'b000100000,
		S_FW_RD  = 9'b001000000,
		S_FW_CMP = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t            state_q;
	item_t             item_q;
	logic [TASK_W-1:0] ptr_q;
	logic [LVL_W-1:0]  ins_lv_q;
	logic [TASK_W-1:0] steps_q;
	logic              found_q;
	logic [STAT_W-1:0] status_q;
	logic [LINK_W-1:0] head_q [NUM_LEVELS];
	logic [LINK_W-1:0] tail_q [NUM_LEVELS];
	logic [LVL_W-1:0]  lvl_q  [MAX_TASKS];
	logic [MAX_TASKS-1:0] queued_q;

	logic [LVL_W-1:0]  lv_sel;
	logic [LINK_W-1:0] head_rd;
	logic [LINK_W-1:0] tail_rd;
	logic [LINK_W-1:0] ptr_link;
	logic              is_push;
	logic              is_front;
	logic              match;
	logic              accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign ptr_link = LINK_W'(ptr_q);
	assign is_push  = (item_q.op <= OP_PUSH_RECV);
	assign is_front = (item_q.op == OP_PUSH_FRONT);
	assign match    = (ram_rd.dest == item_q.wanted_target) &&
	                  (ram_rd.len <= item_q.max_length);
	assign rd_addr  = ptr_q;

	// one level is looked at per cycle
	always_comb begin
		unique case (state_q)
			S_UL_WR: lv_sel = lvl_q[ptr_q];
			S_INS1:  lv_sel = ins_lv_q;
			default: lv_sel = item_q.level;
		endcase
	end

	assign head_rd = head_q[lv_sel];
	assign tail_rd = tail_q[lv_sel];

	always_comb begin
		ram_wr = '0;
		unique case (state_q)
			S_UL_WR: begin
				if (ram_rd.prev != LINK_NONE) begin
					ram_wr.next_we   = 1'b1;
					ram_wr.next_addr = ram_rd.prev[TASK_W-1:0];
					ram_wr.next_data = ram_rd.next;
				end
				if (ram_rd.next != LINK_NONE) begin
					ram_wr.prev_we   = 1'b1;
					ram_wr.prev_addr = ram_rd.next[TASK_W-1:0];
					ram_wr.prev_data = ram_rd.prev;
				end
			end
			S_INS1: begin
				ram_wr.ent_we   = 1'b1;
				ram_wr.ent_addr = ptr_q;
				ram_wr.ent_dest = item_q.destination;
				ram_wr.ent_len  = item_q.msg_length;
				if (head_rd == LINK_NONE) begin
					ram_wr.next_we   = 1'b1;
					ram_wr.next_addr = ptr_q;
					ram_wr.next_data = LINK_NONE;
					ram_wr.prev_we   = 1'b1;
					ram_wr.prev_addr = ptr_q;
					ram_wr.prev_data = LINK_NONE;
				end else if (is_front) begin
					ram_wr.prev_we   = 1'b1;
					ram_wr.prev_addr = head_rd[TASK_W-1:0];
					ram_wr.prev_data = ptr_link;
					ram_wr.next_we   = 1'b1;
					ram_wr.next_addr = ptr_q;
					ram_wr.next_data = head_rd;
				end else begin
					ram_wr.next_we   = 1'b1;
					ram_wr.next_addr = tail_rd[TASK_W-1:0];
					ram_wr.next_data = ptr_link;
					ram_wr.prev_we   = 1'b1;
					ram_wr.prev_addr = ptr_q;
					ram_wr.prev_data = tail_rd;
				end
			end
			S_INS2: begin
				// second link of the new entry
				if (is_front) begin
					ram_wr.prev_we   = 1'b1;
					ram_wr.prev_addr = ptr_q;
					ram_wr.prev_data = LINK_NONE;
				end else begin
					ram_wr.next_we   = 1'b1;
					ram_wr.next_addr = ptr_q;
					ram_wr.next_data = LINK_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ptr_q    <= '0;
			ins_lv_q <= '0;
			steps_q  <= '0;
			found_q  <= 1'b0;
			status_q <= ST_DONE;
			queued_q <= '0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i] <= LINK_NONE;
				tail_q[i] <= LINK_NONE;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ptr_q    <= item.task_id;
						found_q  <= 1'b0;
						status_q <= ST_DONE;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (item_q.op) inside
						OP_PUSH_BACK, OP_PUSH_FRONT, OP_PUSH_RECV: begin
							ins_lv_q <= code_to_level((item_q.op == OP_PUSH_RECV) ?
							                          recv_priority : item_q.priority_req);
							state_q  <= queued_q[ptr_q] ? S_UL_RD : S_INS1;
						end
						OP_POP: begin
							if (head_rd == LINK_NONE) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= head_rd[TASK_W-1:0];
								found_q <= 1'b1;
								state_q <= S_UL_RD;
							end
						end
						OP_REMOVE: begin
							if (queued_q[ptr_q] &&
							    lvl_q[ptr_q] == code_to_level(item_q.priority_req)) begin
								state_q <= S_UL_RD;
							end else begin
								status_q <= ST_NO_MATCH;
								state_q  <= S_DONE;
							end
						end
						OP_FIND: begin
							if (head_rd == LINK_NONE) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= head_rd[TASK_W-1:0];
								steps_q <= '0;
								state_q <= S_FW_RD;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_UL_RD: state_q <= S_UL_WR;
				S_UL_WR: begin
					if (ram_rd.prev == LINK_NONE) begin
						head_q[lv_sel] <= ram_rd.next;
					end
					if (ram_rd.next == LINK_NONE) begin
						tail_q[lv_sel] <= ram_rd.prev;
					end
					queued_q[ptr_q] <= 1'b0;
					state_q         <= is_push ? S_INS1 : S_DONE;
				end
				S_INS1: begin
					queued_q[ptr_q] <= 1'b1;
					if (head_rd == LINK_NONE) begin
						head_q[lv_sel] <= ptr_link;
						tail_q[lv_sel] <= ptr_link;
					end else if (is_front) begin
						head_q[lv_sel] <= ptr_link;
					end else begin
						tail_q[lv_sel] <= ptr_link;
					end
					state_q <= S_INS2;
				end
				S_INS2: state_q <= S_DONE;
				S_FW_RD: state_q <= S_FW_CMP;
				S_FW_CMP: begin
					if (match) begin
						found_q <= 1'b1;
						state_q <= S_UL_WR;
					end else if (ram_rd.next == LINK_NONE ||
					             steps_q == TASK_W'(MAX_TASKS - 1)) begin
						status_q <= ST_NO_MATCH;
						state_q  <= S_DONE;
					end else begin
						ptr_q   <= ram_rd.next[TASK_W-1:0];
						steps_q <= steps_q + 1'b1;
						state_q <= S_FW_RD;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == S_INS1) begin
			lvl_q[ptr_q] <= ins_lv_q;
		end
	end

	assign res_valid    = (state_q == S_DONE) && res_ready;
	assign res.found    = found_q;
	assign res.out_task = found_q ? ptr_q : '0;
	assign res.status   = status_q;

endmodule

### hdl/multilevel_ready_queue_top.sv
// ----------------------------------------------------------------------------
// multilevel_ready_queue_top
// eight linked task queues by level with push, pop, remove and sender search
// ----------------------------------------------------------------------------
// Each input transfer carries one operation and yields exactly one result
// transfer. A small sequencer does the work on the task link store, and the
// block takes no new item until the current one has handed its result to the
// output register. A push decodes, first unlinks the task when it is already
// queued, then links it in two steps; a pop or a remove decodes and unlinks;
// a pop or find of an empty level, a remove that misses and an unused op code
// go straight from decode to the result. Find sender walks the searched level
// one entry at a time (store read, then compare), checking at most 16 entries,
// and unlinks a match without a second read. The result waits in an output
// register, so the next item is taken while a result is still pending on the
// master side; a further result then holds the sequencer until that register
// drains. recv_priority is to be written by the user over the APB-style port
// at byte address 0, only while the block is idle; the block itself does not
// enforce this.
module multilevel_ready_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	// apb-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[2:0], priority_req[10:3], level[13:11], task_id[17:14],
	// destination[25:18], msg_length[41:26], wanted_target[49:42],
	// max_length[65:50], zero pad[71:66]
	input  logic [71:0] s_tdata,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// found[0], out_task[4:1], status[6:5], zero pad[7]
	output logic [7:0]  m_tdata
);
	import mrq_pkg::*;

	// word index of the receive-blocked priority register
	localparam logic REG_IDX_RCV_CODE = 1'b0;

	logic [PRIO_W-1:0] rcv_code_q;
	logic              cfg_write;
	item_t             item;
	result_t           res;
	logic              res_valid;
	logic              res_ready;
	ram_wr_t           ram_wr;
	ram_rd_t           ram_rd;
	logic [TASK_W-1:0] rd_addr;
	logic              m_tvalid_q;
	result_t           m_res_q;

	// configuration: zero wait states, register at word 0
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
	                   (paddr[2] == REG_IDX_RCV_CODE);
	assign prdata    = (paddr[2] == REG_IDX_RCV_CODE) ?
	                   {{(32 - PRIO_W){1'b0}}, rcv_code_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_code_q <= PRIO_LO;
		end else if (cfg_write) begin
			rcv_code_q <= pwdata[PRIO_W-1:0];
		end
	end

	// unpack the input transfer, lowest field first
	assign item = s_tdata[$bits(item_t)-1:0];

	mrq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.item          (item),
		.recv_priority (rcv_code_q),
		.res_ready     (res_ready),
		.res_valid     (res_valid),
		.res           (res),
		.ram_wr        (ram_wr),
		.rd_addr       (rd_addr),
		.ram_rd        (ram_rd)
	);

	mrq_task_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_addr (rd_addr),
		.rd      (ram_rd)
	);

	// output register: loads when empty or being drained in the same cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_res_q};

`ifndef SYNTHESIS
	// the sequencer is busy in the cycle after each input transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted on back-to-back cycles");

	// a new result never overwrites one that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!m_tvalid_q || m_tready))
		else $error("pending result overwritten");

	// a returned task always reports success, no task means a zero id
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.found && res.status == ST_DONE) ||
		               (!res.found && res.out_task == '0)))
		else $error("inconsistent result fields");
`endif

endmodule
